/* rtl/core/triangle_sides_perimeter_area_defines.svh */
// assertion macros shared by the triangle geometry rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TRIANGLE_SIDES_PERIMETER_AREA_DEFINES_SVH
`define TRIANGLE_SIDES_PERIMETER_AREA_DEFINES_SVH

// same-cycle implication, checks disabled while in reset
`define TSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsp check failed");

// next-cycle implication, checks disabled while in reset
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsp check failed");

`endif

/* rtl/core/tsp_pkg.sv */
// widths, constants and payload types for the triangle geometry pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package tsp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 8;

   localparam int MAG_W   = COORD_WIDTH;          // |coordinate difference|
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = 2 * MAG_W + 2;        // sum of three squares
   localparam int SIDE_W  = MAG_W + 1;
   localparam int PERIM_W = SIDE_W + 2;
   localparam int FAC_W   = SIDE_W + 1;           // heron factor magnitude
   localparam int P1_W    = PERIM_W + FAC_W;
   localparam int P2_W    = 2 * FAC_W;
   localparam int P2_LO_W = P2_W / 2;
   localparam int P2_HI_W = P2_W - P2_LO_W;
   localparam int HRAD_W  = 4 * SIDE_W + 6;       // heron product, even width
   localparam int HROOT_W = HRAD_W / 2;
   localparam int AREA_SH = 2 + FRAC_BITS;
   localparam int AREA_W  = 2 * SIDE_W - 1 - FRAC_BITS;

   localparam int DIMS_W = 2;
   localparam logic [DIMS_W-1:0] DIMS_3D    = 2'd3;
   localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] az;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by_coord;
      logic signed [COORD_WIDTH-1:0] bz;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cz;
   } req_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  side_ab;
      logic [SIDE_W-1:0]  side_bc;
      logic [SIDE_W-1:0]  side_ca;
      logic [PERIM_W-1:0] perimeter;
      logic [AREA_W-1:0]  area;
   } rsp_type;

   // what travels alongside the heron product
   typedef struct packed {
      logic               zero;
      logic [PERIM_W-1:0] per;
      logic [SIDE_W-1:0]  ab;
      logic [SIDE_W-1:0]  bc;
      logic [SIDE_W-1:0]  ca;
   } meta_type;

endpackage

`default_nettype wire

/* rtl/core/tsp_isqrt.sv */
// pipelined truncated integer square root, one result bit per stage
// depends on tsp_pkg; LANES roots computed side by side
`default_nettype none

module tsp_isqrt
   import tsp_pkg::*;
#(
   parameter int RES_W = SIDE_W,
   parameter int LANES = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic [LANES-1:0][2*RES_W-1:0]     in_rad,
   output logic                                   out_valid,
   output logic [LANES-1:0][RES_W-1:0]            out_root
);

   localparam int RAD_W = 2 * RES_W;
   localparam int REM_W = RES_W + 2;

   logic [RES_W-1:0]                 vld_ff;
   logic [LANES-1:0][RAD_W-1:0]      rad_ff  [RES_W];
   logic [LANES-1:0][REM_W-1:0]      rem_ff  [RES_W];
   logic [LANES-1:0][RES_W-1:0]      root_ff [RES_W];

   for (genvar k = 0; k < RES_W; k++) begin : g_stage
      logic                         v_prev;
      logic [LANES-1:0][RAD_W-1:0]  rad_prev;
      logic [LANES-1:0][REM_W-1:0]  rem_prev;
      logic [LANES-1:0][RES_W-1:0]  root_prev;
      logic [LANES-1:0][RAD_W-1:0]  rad_in;
      logic [LANES-1:0][REM_W-1:0]  rem_in;
      logic [LANES-1:0][RES_W-1:0]  root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign v_prev    = vld_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [REM_W-1:0] rem_sh;
         logic [REM_W-1:0] trial;
         logic [REM_W:0]   diff;

         always_comb begin
            rem_sh = {rem_prev[l][RES_W-1:0], rad_prev[l][RAD_W-1:RAD_W-2]};
            trial  = {root_prev[l], 2'b01};
            diff   = {1'b0, rem_sh} - {1'b0, trial};
            rad_in[l] = {rad_prev[l][RAD_W-3:0], 2'b00};
            if (!diff[REM_W]) begin
               rem_in[l]  = diff[REM_W-1:0];
               root_in[l] = {root_prev[l][RES_W-2:0], 1'b1};
            end else begin
               rem_in[l]  = rem_sh;
               root_in[l] = {root_prev[l][RES_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = vld_ff[RES_W-1];
   assign out_root  = root_ff[RES_W-1];

endmodule

`default_nettype wire

/* rtl/core/tsp_dist.sv */
// squared side lengths: differences, squares, sums over three stages
// depends on tsp_pkg for the request type and widths
`default_nettype none

module tsp_dist
   import tsp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire req_type                   in_data,
   input  wire logic                      three_d,
   output logic                           out_valid,
   output logic [2:0][SUM_W-1:0]          out_sum
);

   logic [2:0]                     vld_ff;
   logic [2:0][2:0][MAG_W-1:0]     mag_ff;
   logic [2:0][2:0][MAG_W-1:0]     mag_in;
   logic [2:0][2:0][SQ_W-1:0]      sq_ff;
   logic [2:0][SUM_W-1:0]          sum_ff;

   logic signed [COORD_WIDTH-1:0]  pa [3];
   logic signed [COORD_WIDTH-1:0]  pb [3];

   // endpoints per side: ab, bc, ca; axes x, y, z
   always_comb begin
      for (int s = 0; s < 3; s++) begin
         for (int d = 0; d < 3; d++) begin
            logic [COORD_WIDTH-1:0] p;
            logic [COORD_WIDTH-1:0] q;
            logic [COORD_WIDTH:0]   dif;
            logic [COORD_WIDTH:0]   neg;
            case (s)
               0: begin
                  p = (d == 0) ? in_data.ax : (d == 1) ? in_data.ay : in_data.az;
                  q = (d == 0) ? in_data.bx : (d == 1) ? in_data.by_coord : in_data.bz;
               end
               1: begin
                  p = (d == 0) ? in_data.bx : (d == 1) ? in_data.by_coord : in_data.bz;
                  q = (d == 0) ? in_data.cx : (d == 1) ? in_data.cy : in_data.cz;
               end
               default: begin
                  p = (d == 0) ? in_data.cx : (d == 1) ? in_data.cy : in_data.cz;
                  q = (d == 0) ? in_data.ax : (d == 1) ? in_data.ay : in_data.az;
               end
            endcase
            dif = {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
            neg = ~dif + 1'b1;
            mag_in[s][d] = dif[COORD_WIDTH] ? neg[MAG_W-1:0] : dif[MAG_W-1:0];
            if (d == 2 && !three_d) begin
               mag_in[s][d] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         for (int s = 0; s < 3; s++) begin
            for (int d = 0; d < 3; d++) begin
               sq_ff[s][d] <= mag_ff[s][d] * mag_ff[s][d];
            end
            sum_ff[s] <= SUM_W'(sq_ff[s][0]) + SUM_W'(sq_ff[s][1]) + SUM_W'(sq_ff[s][2]);
         end
      end
   end

   assign out_valid = vld_ff[2];
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire

/* rtl/core/tsp_heron.sv */
// heron product from the three sides: factors, two multiply stages, final add
// depends on tsp_pkg for widths and the side-band meta type
`default_nettype none

module tsp_heron
   import tsp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [2:0][SIDE_W-1:0]    in_side,
   output logic                           out_valid,
   output logic [HRAD_W-1:0]              out_rad,
   output meta_type                       out_meta
);

   localparam int F_W = SIDE_W + 2;

   logic [3:0]               vld_ff;
   meta_type                 meta_ff [4];
   meta_type                 meta_in;
   logic [2:0][FAC_W-1:0]    fac_ff;
   logic [2:0][FAC_W-1:0]    fac_in;
   logic [P1_W-1:0]          p1_ff;
   logic [P2_W-1:0]          p2_ff;
   logic [P1_W+P2_LO_W-1:0]  mlo_ff;
   logic [P1_W+P2_HI_W-1:0]  mhi_ff;
   logic [HRAD_W-1:0]        prod_ff;

   always_comb begin
      logic [F_W-1:0] f [3];
      logic [F_W-1:0] fn;
      logic [SIDE_W-1:0] a;
      logic [SIDE_W-1:0] b;
      logic [SIDE_W-1:0] c;
      a = in_side[0];
      b = in_side[1];
      c = in_side[2];
      f[0] = F_W'(b) + F_W'(c) - F_W'(a);
      f[1] = F_W'(a) + F_W'(c) - F_W'(b);
      f[2] = F_W'(a) + F_W'(b) - F_W'(c);
      for (int i = 0; i < 3; i++) begin
         fn = ~f[i] + 1'b1;
         fac_in[i] = f[i][F_W-1] ? fn[FAC_W-1:0] : f[i][FAC_W-1:0];
      end
      meta_in.ab  = a;
      meta_in.bc  = b;
      meta_in.ca  = c;
      meta_in.per = PERIM_W'(a) + PERIM_W'(b) + PERIM_W'(c);
      // flat triangle or an odd number of negative factors gives no area
      meta_in.zero = (meta_in.per == '0) || (f[0] == '0) || (f[1] == '0)
                     || (f[2] == '0)
                     || (f[0][F_W-1] ^ f[1][F_W-1] ^ f[2][F_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k < 4; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         fac_ff  <= fac_in;
         p1_ff   <= P1_W'(meta_ff[0].per) * P1_W'(fac_ff[0]);
         p2_ff   <= P2_W'(fac_ff[1]) * P2_W'(fac_ff[2]);
         // second factor split in halves to keep each multiplier narrow
         mlo_ff  <= (P1_W+P2_LO_W)'(p1_ff) * (P1_W+P2_LO_W)'(p2_ff[P2_LO_W-1:0]);
         mhi_ff  <= (P1_W+P2_HI_W)'(p1_ff) * (P1_W+P2_HI_W)'(p2_ff[P2_W-1:P2_LO_W]);
         prod_ff <= HRAD_W'(mlo_ff) + (HRAD_W'(mhi_ff) << P2_LO_W);
      end
   end

   assign out_valid = vld_ff[3];
   assign out_rad   = prod_ff;
   assign out_meta  = meta_ff[3];

endmodule

`default_nettype wire

/* rtl/core/triangle_sides_perimeter_area.sv */
// Triangle sides, perimeter and Heron area for three points in Q7.8, one
// triangle accepted per cycle while no result is held by rsp_stall. Each
// transfer passes the squared lengths, the side square roots, the Heron
// product, the area square root and the output register before rsp_valid
// rises. The pipeline is frozen as a whole while a result waits on
// rsp_stall; req_stall follows that. Writing csr_data = 3 selects 3-D
// distances, any other value 2-D with the z fields ignored; write it only
// while no items are in flight.
// depends on tsp_pkg, tsp_dist, tsp_isqrt, tsp_heron and the defines header
`default_nettype none

`include "triangle_sides_perimeter_area_defines.svh"

module triangle_sides_perimeter_area
   import tsp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [DIMS_W-1:0]  csr_data
);

   logic [DIMS_W-1:0]          dims_ff;
   logic                       en;
   logic                       d_valid;
   logic [2:0][SUM_W-1:0]      d_sum;
   logic                       s_valid;
   logic [2:0][SIDE_W-1:0]     s_root;
   logic                       h_valid;
   logic [HRAD_W-1:0]          h_rad;
   meta_type                   h_meta;
   logic                       a_valid;
   logic [0:0][HROOT_W-1:0]    a_root;
   meta_type                   meta_ff [HROOT_W];
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;
   rsp_type                    rsp_data_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
      end else if (csr_valid && csr_ready) begin
         dims_ff <= csr_data;
      end
   end

   // whole pipeline advances unless the result is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   tsp_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && !req_stall),
      .in_data   (req_data),
      .three_d   (dims_ff == DIMS_3D),
      .out_valid (d_valid),
      .out_sum   (d_sum)
   );

   tsp_isqrt #(
      .RES_W (SIDE_W),
      .LANES (3)
   ) u_side_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_rad    (d_sum),
      .out_valid (s_valid),
      .out_root  (s_root)
   );

   tsp_heron u_heron (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_side   (s_root),
      .out_valid (h_valid),
      .out_rad   (h_rad),
      .out_meta  (h_meta)
   );

   tsp_isqrt #(
      .RES_W (HROOT_W),
      .LANES (1)
   ) u_area_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (h_valid),
      .in_rad    (h_rad),
      .out_valid (a_valid),
      .out_root  (a_root)
   );

   // side-band delay matching the area root latency
   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= h_meta;
         for (int k = 1; k < HROOT_W; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   always_comb begin
      rsp_data_in.side_ab   = meta_ff[HROOT_W-1].ab;
      rsp_data_in.side_bc   = meta_ff[HROOT_W-1].bc;
      rsp_data_in.side_ca   = meta_ff[HROOT_W-1].ca;
      rsp_data_in.perimeter = meta_ff[HROOT_W-1].per;
      rsp_data_in.area      = meta_ff[HROOT_W-1].zero ? '0
                              : a_root[0][AREA_W+AREA_SH-1:AREA_SH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TSP_ASSERT_IMPL(a_stall_from_output, clock, reset, req_stall, rsp_valid)
   `TSP_ASSERT_IMPL(a_area_needs_sides, clock, reset, rsp_valid && (rsp_data.area != '0),
      (rsp_data.side_ab != '0) && (rsp_data.side_bc != '0) && (rsp_data.side_ca != '0))
   `TSP_ASSERT_IMPL(a_perimeter_sum, clock, reset, rsp_valid,
      rsp_data.perimeter == PERIM_W'(rsp_data.side_ab) + PERIM_W'(rsp_data.side_bc)
                            + PERIM_W'(rsp_data.side_ca))

endmodule

`default_nettype wire
